### sv/dss_pkg.sv
`timescale 1ns / 1ps
// dss_pkg: shared constants, types and month table for the date span core.
// No dependencies; used by date_span_seconds_core.
package dss_pkg;

    localparam int YEAR_BITS_DEF = 12;
    localparam int MONTH_W       = 4;
    localparam int DAY_W         = 5;
    localparam int SPAN_W        = 37;
    localparam int ERR_W         = 2;
    localparam int M_TDATA_W     = ((SPAN_W + ERR_W + 7) / 8) * 8;
    localparam int DBM_W         = 9;     // days before month, up to 334
    localparam int DAYS_PER_YEAR = 365;
    localparam int SECS_PER_DAY  = 86400;
    localparam int SECS_W        = 17;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE  = 2'd0,
        ERR_YEAR  = 2'd1,
        ERR_MONTH = 2'd2,
        ERR_DAY   = 2'd3
    } order_err_t;

    // month 0 reads as January, 13..15 as December
    function automatic logic [MONTH_W-1:0] clamp_month(input logic [MONTH_W-1:0] m);
        logic [MONTH_W-1:0] r;
        r = m;
        if (m == MONTH_W'(0)) begin
            r = MONTH_W'(1);
        end else if (m > MONTH_W'(12)) begin
            r = MONTH_W'(12);
        end
        return r;
    endfunction

    // cumulative days before the month, common year; month already clamped
    function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DBM_W-1:0] r;
        unique case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

### sv/date_span_seconds_core.sv
`timescale 1ns / 1ps
// date_span_seconds_core: inclusive span in seconds between two calendar dates.
// Depends on dss_pkg (constants, error codes, month table).
//
// Usage
//   Input channel s_axis_*: one word carries a start date and an end date.
//   Output channel m_axis_*: one word per input word, carrying the inclusive
//   span in seconds (day count times 86400) and an order error code.
//   Months outside 1..12 are clamped; days are taken at face value as an
//   offset into their month. Leap years follow the Julian rule (every year
//   divisible by 4). An end date before the start date gives a nonzero
//   error code and a zero span; a negative day count gives a zero span.
// Timing
//   Three register stages: input register, day ordinals plus order check,
//   then difference times 86400 into the output register. m_axis_tvalid
//   rises when the word reaches the output register by way of the middle
//   stage; one word per cycle sustained while m_axis_tready stays high.
//   The two ordinal multiplies by 365 and the final multiply by 86400 sit
//   in separate stages, which sets the pipeline depth.
// Reset and stall
//   aresetn (synchronous, active low) empties all stages. When the receiver
//   holds m_axis_tready low, each stage keeps accepting until it is full, so
//   up to three words are held before s_axis_tready drops.
module date_span_seconds_core #(
    parameter int YEAR_BITS = dss_pkg::YEAR_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_axis_tdata, from bit 0: start_year, start_month, start_day,
    //                           end_year, end_month, end_day, zero fill
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [((2 * (YEAR_BITS + dss_pkg::MONTH_W + dss_pkg::DAY_W) + 7) / 8) * 8 - 1:0]
                                          s_axis_tdata,
    // m_axis_tdata, from bit 0: span_seconds, order_error, zero fill
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [dss_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int MW        = dss_pkg::MONTH_W;
    localparam int DW        = dss_pkg::DAY_W;
    localparam int DATE_W    = YEAR_BITS + MW + DW;
    localparam int IN_W      = 2 * DATE_W;
    // ordinal: y*365 + y/4 + 366 + 31 fits in YEAR_BITS + 9 bits
    localparam int ORD_W     = YEAR_BITS + 9;
    localparam int DIFF_W    = ORD_W + 1;
    localparam int PROD_W    = ORD_W + dss_pkg::SECS_W;

    // field offsets inside s_axis_tdata
    localparam int SY_LO = 0;
    localparam int SM_LO = SY_LO + YEAR_BITS;
    localparam int SD_LO = SM_LO + MW;
    localparam int EY_LO = SD_LO + DW;
    localparam int EM_LO = EY_LO + YEAR_BITS;
    localparam int ED_LO = EM_LO + MW;

    // days from start of year 0 to the date, day taken as offset
    function automatic logic [ORD_W-1:0] day_ordinal(
        input logic [YEAR_BITS-1:0] y,
        input logic [MW-1:0]        m,
        input logic [DW-1:0]        d
    );
        logic [YEAR_BITS:0] yp3;
        logic [ORD_W-1:0]   n;
        yp3 = {1'b0, y} + (YEAR_BITS + 1)'(3);
        n   = ORD_W'(y) * ORD_W'(dss_pkg::DAYS_PER_YEAR);
        n   = n + ORD_W'(yp3 >> 2);
        n   = n + ORD_W'(dss_pkg::days_before_month(m));
        if (m > MW'(2) && y[1:0] == 2'b00) begin
            n = n + ORD_W'(1);
        end
        return n + ORD_W'(d);
    endfunction

    // ---------------- handshake chain ----------------
    logic s1_vld_reg, s1_vld_next;
    logic s2_vld_reg, s2_vld_next;
    logic out_vld_reg, out_vld_next;
    logic out_rdy, s2_rdy, s1_rdy;

    assign out_rdy       = !out_vld_reg || m_axis_tready;
    assign s2_rdy        = !s2_vld_reg || out_rdy;
    assign s1_rdy        = !s1_vld_reg || s2_rdy;
    assign s_axis_tready = s1_rdy;

    // ---------------- stage 1: input register ----------------
    logic [IN_W-1:0] s1_data_reg;

    // ---------------- stage 2: ordinals and order check ----------------
    logic [YEAR_BITS-1:0]  sy, ey;
    logic [MW-1:0]         sm, em;
    logic [DW-1:0]         sd, ed;
    logic [ORD_W-1:0]      ord_s, ord_e;
    dss_pkg::order_err_t   err_next;
    logic [ORD_W-1:0]      s2_ord_s_reg, s2_ord_e_reg;
    dss_pkg::order_err_t   s2_err_reg;

    always_comb begin
        sy    = s1_data_reg[SY_LO +: YEAR_BITS];
        sm    = dss_pkg::clamp_month(s1_data_reg[SM_LO +: MW]);
        sd    = s1_data_reg[SD_LO +: DW];
        ey    = s1_data_reg[EY_LO +: YEAR_BITS];
        em    = dss_pkg::clamp_month(s1_data_reg[EM_LO +: MW]);
        ed    = s1_data_reg[ED_LO +: DW];
        ord_s = day_ordinal(sy, sm, sd);
        ord_e = day_ordinal(ey, em, ed);
        priority if (ey < sy) begin
            err_next = dss_pkg::ERR_YEAR;
        end else if (ey == sy && em < sm) begin
            err_next = dss_pkg::ERR_MONTH;
        end else if (ey == sy && em == sm && ed < sd) begin
            err_next = dss_pkg::ERR_DAY;
        end else begin
            err_next = dss_pkg::ERR_NONE;
        end
    end

    // ---------------- stage 3: day count times 86400 ----------------
    logic signed [DIFF_W-1:0]   diff;
    logic [ORD_W-1:0]           days;
    logic [PROD_W-1:0]          prod;
    logic [dss_pkg::SPAN_W-1:0] span_next;
    logic [dss_pkg::SPAN_W-1:0] out_span_reg;
    dss_pkg::order_err_t        out_err_reg;

    always_comb begin
        diff = $signed({1'b0, s2_ord_e_reg}) - $signed({1'b0, s2_ord_s_reg})
             + DIFF_W'(1);
        days = (diff > 0) ? diff[ORD_W-1:0] : '0;
        prod = PROD_W'(days) * PROD_W'(dss_pkg::SECS_PER_DAY);
        if (s2_err_reg == dss_pkg::ERR_NONE) begin
            span_next = dss_pkg::SPAN_W'(prod);
        end else begin
            span_next = '0;
        end
    end

    // ---------------- valid bits ----------------
    always_comb begin
        s1_vld_next  = s1_rdy ? s_axis_tvalid : s1_vld_reg;
        s2_vld_next  = s2_rdy ? s1_vld_reg : s2_vld_reg;
        out_vld_next = out_rdy ? s2_vld_reg : out_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg  <= s1_vld_next;
            s2_vld_reg  <= s2_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s1_rdy) begin
            s1_data_reg <= s_axis_tdata[IN_W-1:0];
        end
        if (s2_rdy) begin
            s2_ord_s_reg <= ord_s;
            s2_ord_e_reg <= ord_e;
            s2_err_reg   <= err_next;
        end
        if (out_rdy) begin
            out_span_reg <= span_next;
            out_err_reg  <= s2_err_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = dss_pkg::M_TDATA_W'({out_err_reg, out_span_reg});

    // ---------------- assertions ----------------
    // a flagged order error always comes with a zero span
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && out_err_reg != dss_pkg::ERR_NONE) |-> (out_span_reg == '0))
        else $error("span not zero with order error");

    // an accepted word lands in the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> s1_vld_reg)
        else $error("accepted word lost at input register");

    // a stalled middle-stage word stays until it moves on
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_vld_reg && !s2_rdy) |=> (s2_vld_reg && $stable(s2_ord_s_reg)
                                     && $stable(s2_ord_e_reg)))
        else $error("middle stage overwritten while stalled");

    // reset empties the output stage
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for date_span_seconds_core, directed table plus random date pairs.
// Depends on dss_pkg and date_span_seconds_core; the expected spans come from the directed table or a local predictor.
module testbench;

    localparam int YEAR_W         = dss_pkg::YEAR_BITS_DEF;
    localparam int MONTH_W        = dss_pkg::MONTH_W;
    localparam int DAY_W          = dss_pkg::DAY_W;
    localparam int SPAN_W         = dss_pkg::SPAN_W;
    localparam int PAIR_W         = 2 * (YEAR_W + MONTH_W + DAY_W);
    localparam int S_TDATA_W      = ((PAIR_W + 7) / 8) * 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 8;    // pipeline is 3 deep, leave some slack
    localparam int RANDOM_WORDS   = 1630;
    localparam int NUM_DIRECTED   = 23;

    // packed so that {fill, pair} is the input word: start_year sits in bit 0
    typedef struct packed {
        logic [DAY_W-1:0]   ed;
        logic [MONTH_W-1:0] em;
        logic [YEAR_W-1:0]  ey;
        logic [DAY_W-1:0]   sd;
        logic [MONTH_W-1:0] sm;
        logic [YEAR_W-1:0]  sy;
    } date_pair_t;

    typedef struct packed {
        logic [SPAN_W-1:0]   span;
        dss_pkg::order_err_t err;
    } span_result_t;

    // known = 1: expectation typed in the row, otherwise taken from the predictor
    typedef struct {
        int                  sy, sm, sd, ey, em, ed;
        bit                  known;
        longint              span;
        dss_pkg::order_err_t err;
    } directed_row_t;

    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{0,    1,  1,  0,    1,  1,  1'b1, 86400,   dss_pkg::ERR_NONE},   // same day
        '{0,    0,  0,  0,    0,  0,  1'b1, 86400,   dss_pkg::ERR_NONE},   // all fields zero
        '{4095, 15, 31, 4095, 15, 31, 1'b1, 86400,   dss_pkg::ERR_NONE},   // all fields at max
        '{0,    1,  1,  4095, 12, 31, 1'b0, 0,       dss_pkg::ERR_NONE},
        '{0,    0,  0,  4095, 15, 31, 1'b0, 0,       dss_pkg::ERR_NONE},   // widest span
        '{5,    1,  1,  4,    12, 31, 1'b1, 0,       dss_pkg::ERR_YEAR},
        '{4095, 1,  1,  0,    12, 31, 1'b1, 0,       dss_pkg::ERR_YEAR},
        '{2000, 6,  1,  2000, 5,  31, 1'b1, 0,       dss_pkg::ERR_MONTH},
        '{2000, 6,  15, 2000, 6,  14, 1'b1, 0,       dss_pkg::ERR_DAY},
        '{2000, 0,  5,  2000, 1,  5,  1'b1, 86400,   dss_pkg::ERR_NONE},   // month 0 is Jan
        '{2000, 15, 3,  2000, 12, 3,  1'b1, 86400,   dss_pkg::ERR_NONE},   // month 15 is Dec
        '{2000, 13, 3,  2000, 12, 2,  1'b1, 0,       dss_pkg::ERR_DAY},    // clamped months tie
        '{7,    1,  9,  7,    0,  8,  1'b1, 0,       dss_pkg::ERR_DAY},
        '{2000, 2,  1,  2000, 0,  31, 1'b1, 0,       dss_pkg::ERR_MONTH},  // clamp drives check
        '{2001, 2,  31, 2001, 3,  1,  1'b1, 0,       dss_pkg::ERR_NONE},   // negative count
        '{2001, 2,  30, 2001, 3,  1,  1'b1, 0,       dss_pkg::ERR_NONE},   // zero count
        '{2001, 2,  29, 2001, 3,  1,  1'b1, 86400,   dss_pkg::ERR_NONE},   // Feb 29 is Mar 1
        '{2004, 2,  28, 2004, 3,  1,  1'b0, 0,       dss_pkg::ERR_NONE},   // leap year
        '{0,    2,  28, 0,    3,  1,  1'b0, 0,       dss_pkg::ERR_NONE},   // year 0 is leap
        '{1900, 2,  1,  1900, 3,  1,  1'b0, 0,       dss_pkg::ERR_NONE},   // Julian: 1900 leap
        '{2003, 12, 31, 2004, 1,  1,  1'b0, 0,       dss_pkg::ERR_NONE},
        '{2004, 1,  1,  2004, 12, 31, 1'b0, 0,       dss_pkg::ERR_NONE},
        '{0,    1,  0,  0,    1,  31, 1'b1, 2764800, dss_pkg::ERR_NONE}    // day 0 to 31: 32 days
    };

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [S_TDATA_W-1:0]          s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [dss_pkg::M_TDATA_W-1:0] m_axis_tdata;

    span_result_t span_expect_q [$];
    span_result_t next_expect;          // expectation for the word now on s_axis_tdata
    span_result_t got_res, want_res;
    int           mismatch_count = 0;
    int           stall_cycles = 0;
    int           rx_left = 0;
    int           rx_gap;
    logic [11:0]  rx_cycle = '0;

    date_span_seconds_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // days since the start of year 0, with the day taken as a raw offset
    function automatic longint day_number(input longint y, input int m, input longint d);
        longint n;
        n = y * 365 + (y + 3) / 4 + d;
        case (m)
            1:  n += 0;
            2:  n += 31;
            3:  n += 59;
            4:  n += 90;
            5:  n += 120;
            6:  n += 151;
            7:  n += 181;
            8:  n += 212;
            9:  n += 243;
            10: n += 273;
            11: n += 304;
            default: n += 334;
        endcase
        if (m > 2 && (y % 4) == 0) n += 1;
        return n;
    endfunction

    function automatic span_result_t predict_span(input date_pair_t p);
        span_result_t r;
        int           s_mon, e_mon;
        longint       days;
        s_mon = (p.sm == 0) ? 1 : ((p.sm > 12) ? 12 : int'(p.sm));
        e_mon = (p.em == 0) ? 1 : ((p.em > 12) ? 12 : int'(p.em));
        r.span = '0;
        r.err  = dss_pkg::ERR_NONE;
        if (p.ey < p.sy) begin
            r.err = dss_pkg::ERR_YEAR;
        end else if (p.ey == p.sy && e_mon < s_mon) begin
            r.err = dss_pkg::ERR_MONTH;
        end else if (p.ey == p.sy && e_mon == s_mon && p.ed < p.sd) begin
            r.err = dss_pkg::ERR_DAY;
        end else begin
            days = day_number(p.ey, e_mon, p.ed) - day_number(p.sy, s_mon, p.sd) + 1;
            if (days > 0) r.span = SPAN_W'(days * dss_pkg::SECS_PER_DAY);
        end
        return r;
    endfunction

    // mostly back to back, sometimes a few cycles, rarely a long hole
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // one word on the input channel; returns at the edge that accepts it
    task automatic send_word(input date_pair_t p, input span_result_t want, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - PAIR_W){1'b0}}, p};
        next_expect   <= want;
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // hold the sender until every expected word has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (span_expect_q.size() != 0) @(posedge aclk);
    endtask

    // receiver: random ready pattern, with a free-running stretch now and then
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1'b1;
        if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else if (m_axis_tready && rx_cycle[10:8] != 3'd5) begin
            rx_gap = pick_gap();
            if (rx_gap != 0) begin
                m_axis_tready <= 1'b0;
                rx_left       <= rx_gap - 1;
            end else begin
                rx_left <= $urandom_range(0, 15);
            end
        end else begin
            m_axis_tready <= 1'b1;
            rx_left       <= $urandom_range(0, 15);
        end
    end

    // scoreboard and watchdog; values sampled here are those before the edge
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            span_expect_q.push_back(next_expect);
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got_res.span = m_axis_tdata[SPAN_W-1:0];
            got_res.err  = dss_pkg::order_err_t'(m_axis_tdata[SPAN_W +: dss_pkg::ERR_W]);
            if (span_expect_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word span=%0d err=%0d",
                                          got_res.span, got_res.err));
            end else begin
                want_res = span_expect_q.pop_front();
                if (got_res.span !== want_res.span) begin
                    report_mismatch($sformatf("span_seconds got %0d want %0d",
                                              got_res.span, want_res.span));
                end
                if (got_res.err !== want_res.err) begin
                    report_mismatch($sformatf("order_error got %0d want %0d",
                                              got_res.err, want_res.err));
                end
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("** date_span_seconds_core: FAILED **");
            $finish;
        end
    end

    initial begin
        date_pair_t   pair;
        span_result_t want;
        date_pair_t   tmp;
        int           mode;
        bit           ordered;
        bit           burst;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            pair.sy = YEAR_W'(directed_rows[i].sy);
            pair.sm = MONTH_W'(directed_rows[i].sm);
            pair.sd = DAY_W'(directed_rows[i].sd);
            pair.ey = YEAR_W'(directed_rows[i].ey);
            pair.em = MONTH_W'(directed_rows[i].em);
            pair.ed = DAY_W'(directed_rows[i].ed);
            if (directed_rows[i].known) begin
                want.span = SPAN_W'(directed_rows[i].span);
                want.err  = directed_rows[i].err;
            end else begin
                want = predict_span(pair);
            end
            send_word(pair, want, 1'b0);
        end
        drain_results();

        // random pairs: mostly well ordered, the rest raw noise (about half of them order errors)
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            pair.sy = YEAR_W'($urandom);
            pair.ey = YEAR_W'($urandom);
            mode    = $urandom_range(0, 9);
            if (mode < 4) begin
                pair.ey = pair.sy;
            end else if (mode < 6) begin
                pair.ey = pair.sy + YEAR_W'($urandom_range(0, 2)) - 1'b1;
            end
            if ($urandom_range(0, 6) == 0) begin
                pair.sm = MONTH_W'($urandom);
                pair.em = MONTH_W'($urandom);
            end else begin
                pair.sm = MONTH_W'($urandom_range(1, 12));
                pair.em = MONTH_W'($urandom_range(1, 12));
            end
            if ($urandom_range(0, 2) == 0) pair.em = pair.sm;
            pair.sd = DAY_W'($urandom);
            pair.ed = DAY_W'($urandom);
            ordered = ($urandom_range(0, 99) < 75);
            want    = predict_span(pair);
            if (ordered && want.err != dss_pkg::ERR_NONE) begin
                tmp     = pair;
                pair.sy = tmp.ey;
                pair.sm = tmp.em;
                pair.sd = tmp.ed;
                pair.ey = tmp.sy;
                pair.em = tmp.sm;
                pair.ed = tmp.sd;
            end
            burst = ((i / 64) % 4 == 1);
            send_word(pair, predict_span(pair), burst);
            if (i % 400 == 399) drain_results();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("** date_span_seconds_core: PASSED **");
        end else begin
            $display("** date_span_seconds_core: FAILED **");
        end
        $finish;
    end

endmodule

### filelist.f
sv/dss_pkg.sv
sv/date_span_seconds_core.sv
bench/testbench.sv
